@@ hdl/mptd_pkg.sv @@
// Shared types, constants and the letter table for the Morse pulse timing decoder.
`default_nettype none

package mptd_pkg;

    localparam int unsigned MAX_SYMBOLS_DEF = 4;
    localparam int unsigned QUEUE_DEPTH     = 2;

    localparam int unsigned TW = 16;   // timer / threshold width
    localparam int unsigned LW = 8;    // letter width
    localparam int unsigned SW = 2;    // status width
    localparam int unsigned AW = 2;    // config index width

    localparam logic [TW-1:0] DOT_MIN_RST  = 16'd50;
    localparam logic [TW-1:0] DASH_MIN_RST = 16'd2500;
    localparam logic [TW-1:0] GAP_MIN_RST  = 16'd20000;

    localparam logic [AW-1:0] REG_DOT_MIN  = 2'd0;
    localparam logic [AW-1:0] REG_DASH_MIN = 2'd1;
    localparam logic [AW-1:0] REG_GAP_MIN  = 2'd2;

    localparam logic [SW-1:0] ST_OK      = 2'd0;
    localparam logic [SW-1:0] ST_UNKNOWN = 2'd1;
    localparam logic [SW-1:0] ST_LONG    = 2'd2;

    // Work handed from the edge classifier to the symbol engine.
    typedef enum logic [1:0] {
        OP_DOT,
        OP_DASH,
        OP_END
    } op_t;

    typedef struct packed {
        logic push;
        op_t  op;
    } q_req_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } q_head_t;

    // Index is a leading marker bit at position count, then the dash bits.
    function automatic logic [LW-1:0] letter_lookup(input logic [4:0] idx);
        logic [LW-1:0] ch;
        case (idx)
            5'd2:    ch = "E";
            5'd3:    ch = "T";
            5'd4:    ch = "I";
            5'd5:    ch = "N";
            5'd6:    ch = "A";
            5'd7:    ch = "M";
            5'd8:    ch = "S";
            5'd9:    ch = "D";
            5'd10:   ch = "R";
            5'd11:   ch = "G";
            5'd12:   ch = "U";
            5'd13:   ch = "K";
            5'd14:   ch = "W";
            5'd15:   ch = "O";
            5'd16:   ch = "H";
            5'd17:   ch = "B";
            5'd18:   ch = "L";
            5'd19:   ch = "Z";
            5'd20:   ch = "F";
            5'd21:   ch = "C";
            5'd22:   ch = "P";
            5'd24:   ch = "V";
            5'd25:   ch = "X";
            5'd27:   ch = "Q";
            5'd29:   ch = "Y";
            5'd30:   ch = "J";
            default: ch = '0;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

@@ hdl/mptd_front.sv @@
// Edge front end: threshold registers, last edge time and edge classification.
`default_nettype none

module mptd_front (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [mptd_pkg::TW-1:0] capture_time,
    input  wire logic                    rising,
    input  wire logic                    cfg_we,
    input  wire logic [mptd_pkg::AW-1:0] cfg_index,
    input  wire logic [mptd_pkg::TW-1:0] cfg_wdata,
    input  wire logic                    q_full,
    output mptd_pkg::q_req_t             q_req
);
    import mptd_pkg::*;

    logic [TW-1:0] dot_min_reg, dash_min_reg, gap_min_reg;
    logic [TW-1:0] last_edge_reg, last_edge_next;
    logic [TW-1:0] span;
    logic          accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign span     = capture_time - last_edge_reg;   // wraps mod 2^16

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_min_reg  <= DOT_MIN_RST;
            dash_min_reg <= DASH_MIN_RST;
            gap_min_reg  <= GAP_MIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DOT_MIN:  dot_min_reg  <= cfg_wdata;
                REG_DASH_MIN: dash_min_reg <= cfg_wdata;
                REG_GAP_MIN:  gap_min_reg  <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    assign last_edge_next = accept ? capture_time : last_edge_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_edge_reg <= '0;
        else
            last_edge_reg <= last_edge_next;
    end

    always_comb
    begin
        q_req.push = 1'b0;
        q_req.op   = OP_DOT;
        if (rising)
        begin
            if (span > gap_min_reg)
            begin
                q_req.push = accept;
                q_req.op   = OP_END;
            end
        end
        else if (span > dot_min_reg && span < dash_min_reg)
        begin
            q_req.push = accept;
            q_req.op   = OP_DOT;
        end
        else if (span > dash_min_reg)
        begin
            q_req.push = accept;
            q_req.op   = OP_DASH;
        end
    end

endmodule

`default_nettype wire

@@ hdl/mptd_queue.sv @@
// Short op queue between the front end and the symbol engine.
`default_nettype none

module mptd_queue #(
    parameter int unsigned DEPTH = mptd_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mptd_pkg::q_req_t req,
    output logic                  full,
    output mptd_pkg::q_head_t     head,
    input  wire logic             pop
);
    import mptd_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    op_t           mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign full      = (cnt_reg == CW'(DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.op   = mem[rd_ptr_reg];
    assign do_push   = req.push && !full;
    assign do_pop    = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = do_push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CW'(1);
        else if (!do_push && do_pop)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= req.op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/mptd_back.sv @@
// Symbol engine: symbol store, letter lookup and the output word register.
`default_nettype none

module mptd_back #(
    parameter int unsigned MAX_SYMBOLS = mptd_pkg::MAX_SYMBOLS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire mptd_pkg::q_head_t       head,
    output logic                         pop,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [mptd_pkg::LW-1:0]      letter,
    output logic [mptd_pkg::SW-1:0]      status
);
    import mptd_pkg::*;

    localparam int unsigned CW = $clog2(MAX_SYMBOLS + 2);

    logic [MAX_SYMBOLS-1:0] pat_reg, pat_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   ov_reg, ov_next;
    logic [LW-1:0]          letter_reg, letter_next;
    logic [SW-1:0]          status_reg, status_next;
    logic                   emit;
    logic [4:0]             idx;
    logic [LW-1:0]          lut_ch;

    assign pop  = head.valid && (!ov_reg || out_ready);
    assign emit = pop && head.op == OP_END && cnt_reg != '0;

    // Only meaningful for counts 1..4; marker bit at the count position.
    assign idx    = (5'd1 << cnt_reg) | 5'(pat_reg[3:0]);
    assign lut_ch = letter_lookup(idx);

    always_comb
    begin
        pat_next = pat_reg;
        cnt_next = cnt_reg;
        if (pop)
        begin
            case (head.op)
                OP_DOT, OP_DASH:
                begin
                    if (cnt_reg < CW'(MAX_SYMBOLS))
                    begin
                        if (head.op == OP_DASH)
                            pat_next = pat_reg | (MAX_SYMBOLS'(1) << cnt_reg);
                        cnt_next = cnt_reg + CW'(1);
                    end
                    else
                        cnt_next = CW'(MAX_SYMBOLS + 1);
                end
                OP_END:
                begin
                    if (cnt_reg != '0)
                    begin
                        pat_next = '0;
                        cnt_next = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        letter_next = '0;
        if (cnt_reg > CW'(MAX_SYMBOLS))
            status_next = ST_LONG;
        else if (cnt_reg <= CW'(4))
        begin
            letter_next = lut_ch;
            status_next = (lut_ch != '0) ? ST_OK : ST_UNKNOWN;
        end
        else
            status_next = ST_UNKNOWN;
    end

    assign ov_next = emit || (ov_reg && !out_ready);

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            letter_reg <= letter_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg <= '0;
            cnt_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            pat_reg <= pat_next;
            cnt_reg <= cnt_next;
            ov_reg  <= ov_next;
        end
    end

    assign out_valid = ov_reg;
    assign letter    = letter_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

@@ hdl/morse_pulse_timing_decoder.sv @@
// Path: the closing edge word is written into the op queue; the engine pops it from there
// and loads the letter word into the output reg, from which it is taken.
// Throughput: one edge word per cycle; the front end stalls only when the two-entry op
// queue is full, and the engine retires one op per cycle while the output reg is free or taken.
// Reset (rst_n, async, active low): thresholds return to 50/2500/20000; last edge time,
// symbol store, queue and output valid clear; ready is already high during reset, as the queue is empty.
`default_nettype none

module morse_pulse_timing_decoder #(
    parameter int unsigned MAX_SYMBOLS = mptd_pkg::MAX_SYMBOLS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // edge word channel
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [mptd_pkg::TW-1:0] capture_time,
    input  wire logic                    rising,
    // letter word channel
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [mptd_pkg::LW-1:0]      letter,
    output logic [mptd_pkg::SW-1:0]      status,
    // threshold writes: 0 dot_min, 1 dash_min, 2 gap_min
    input  wire logic                    cfg_we,
    input  wire logic [mptd_pkg::AW-1:0] cfg_index,
    input  wire logic [mptd_pkg::TW-1:0] cfg_wdata
);
    import mptd_pkg::*;

    q_req_t  q_req;
    q_head_t q_head;
    logic    q_full;
    logic    q_pop;

    // Front end: measures the wrapped span to the previous edge and turns the
    // edge into dot, dash or end-of-letter ops. Short presses and short gaps
    // produce nothing and never touch the queue.
    mptd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .capture_time (capture_time),
        .rising       (rising),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .q_full       (q_full),
        .q_req        (q_req)
    );

    // Decouples edge intake from a stalled letter consumer.
    mptd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (q_req),
        .full  (q_full),
        .head  (q_head),
        .pop   (q_pop)
    );

    // Symbol engine: owns the dot/dash store; an end op with symbols held
    // loads the output word and clears the store.
    mptd_back #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .letter    (letter),
        .status    (status)
    );

endmodule

`default_nettype wire

@@ hdl/mptd_checker.sv @@
// Port-level checker for the Morse pulse timing decoder, with its bind.
`default_nettype none

module mptd_checker (
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_valid,
    input wire logic                    in_ready,
    input wire logic [mptd_pkg::TW-1:0] capture_time,
    input wire logic                    rising,
    input wire logic                    out_valid,
    input wire logic                    out_ready,
    input wire logic [mptd_pkg::LW-1:0] letter,
    input wire logic [mptd_pkg::SW-1:0] status
);
    import mptd_pkg::*;

    // stalled edge word holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(capture_time) && $stable(rising))
        else $error("edge word changed while stalled");

    // stalled letter word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(letter) && $stable(status))
        else $error("letter word changed while stalled");

    a_ok_letter: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK |-> letter >= "A" && letter <= "Z")
        else $error("ok status without a letter A-Z");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> letter == '0)
        else $error("error status with nonzero letter");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == ST_OK || status == ST_UNKNOWN || status == ST_LONG)
        else $error("undefined status code");

endmodule

bind morse_pulse_timing_decoder mptd_checker u_mptd_checker (.*);

`default_nettype wire

@@ tb/morse_pulse_timing_decoder_tb.sv @@
// Self-checking testbench for the Morse key timing decoder: directed table, then random keying.
module morse_pulse_timing_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mptd_pkg::*;

    localparam int   MAX_SYM       = MAX_SYMBOLS_DEF;
    localparam logic KEY_DOWN      = 1'b1;   // rising edge word: key pressed
    localparam logic KEY_UP        = 1'b0;   // falling edge word: key released
    localparam int   SETTLE_CYCLES = 8;      // queue + output reg, with margin
    localparam int   HOLD_CYCLES   = 300;    // long receiver hold-off
    localparam int   STALL_LIMIT   = 3000;   // cycles with no word moving on either side

    typedef struct packed {
        logic [LW-1:0] letter;
        logic [SW-1:0] status;
    } letter_word_t;

    // One directed edge word; typed rows carry the letter word they must produce.
    typedef struct packed {
        logic [TW-1:0] t;
        logic          r;
        logic          typed;
        letter_word_t  w;
    } stim_row_t;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    logic [TW-1:0] capture_time;
    logic          rising;
    logic          out_valid;
    logic          out_ready;
    logic [LW-1:0] letter;
    logic [SW-1:0] status;
    logic          cfg_we;
    logic [AW-1:0] cfg_index;
    logic [TW-1:0] cfg_wdata;

    // Decoder mirror: thresholds, last edge time and the symbol store.
    logic [LW-1:0]      morse_char [32];
    logic [TW-1:0]      dot_min_q   = DOT_MIN_RST;
    logic [TW-1:0]      dash_min_q  = DASH_MIN_RST;
    logic [TW-1:0]      gap_min_q   = GAP_MIN_RST;
    logic [TW-1:0]      edge_time_q = '0;
    logic [MAX_SYM-1:0] sym_pattern = '0;
    logic [2:0]         sym_count   = '0;

    letter_word_t letters_due [$];   // letter words still owed by the block
    stim_row_t    stim_table  [$];

    logic [TW-1:0] key_time     = '0;  // timer value of the last edge word sent
    int            words_sent   = 0;
    int            burst_left   = 0;
    int            errors       = 0;
    int            stall_cycles = 0;
    bit            hold_req     = 1'b0;

    morse_pulse_timing_decoder u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .capture_time(capture_time),
        .rising      (rising),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .letter      (letter),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Builds the letter table: marker bit at position len, symbol k in bit k, 1 = dash.
    task automatic learn_code(input string code, input logic [LW-1:0] ch);
        int idx;
        idx = 1 << code.len();
        for (int k = 0; k < code.len(); k++)
            if (code[k] == "-")
                idx |= 1 << k;
        morse_char[idx] = ch;
    endtask

    task automatic add_row(input logic [TW-1:0] t, input logic r, input logic typed,
                           input logic [LW-1:0] l, input logic [SW-1:0] s);
        stim_row_t row;
        row.t        = t;
        row.r        = r;
        row.typed    = typed;
        row.w.letter = l;
        row.w.status = s;
        stim_table.push_back(row);
    endtask

    // Mirror of one accepted edge word. Returns 1 when a letter word is due.
    function automatic bit decode_edge(input logic [TW-1:0] t, input logic r,
                                       output letter_word_t w);
        logic [TW-1:0] span;
        int            idx;
        span        = t - edge_time_q;   // wraps mod 2^16
        edge_time_q = t;
        w           = '0;
        if (r == KEY_UP)
        begin
            // press length: above dot_min and below dash_min is a dot, above dash_min a dash
            if ((span > dot_min_q && span < dash_min_q) || span > dash_min_q)
            begin
                if (sym_count < MAX_SYM)
                begin
                    if (span > dash_min_q)
                        sym_pattern[sym_count] = 1'b1;
                    sym_count = sym_count + 3'd1;
                end
                else
                    sym_count = 3'(MAX_SYM + 1);   // overlong, sticks
            end
            return 1'b0;
        end
        // key pressed: a long enough gap closes the letter, if anything is held
        if (span <= gap_min_q || sym_count == 0)
            return 1'b0;
        if (sym_count > MAX_SYM)
        begin
            w.letter = '0;
            w.status = ST_LONG;
        end
        else
        begin
            idx      = (1 << sym_count) | sym_pattern;
            w.letter = morse_char[idx];
            w.status = (w.letter != '0) ? ST_OK : ST_UNKNOWN;
        end
        sym_pattern = '0;
        sym_count   = '0;
        return 1'b1;
    endfunction

    // Offers one edge word, holds it until taken, then books the letter word it causes.
    // Called and returns at a rising edge. Bursts of random length with random gaps.
    task automatic send_word(input logic [TW-1:0] t, input logic r, input logic typed,
                             input letter_word_t typed_w);
        bit           taken;
        bit           due;
        letter_word_t w;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid     <= 1'b1;
        capture_time <= t;
        rising       <= r;
        // ready is stable at the falling edge; it decides the next rising edge
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        words_sent++;
        key_time = t;
        due = decode_edge(t, r, w);
        if (typed)
            letters_due.push_back(typed_w);
        else if (due)
            letters_due.push_back(w);
    endtask

    task automatic key_after(input int span, input logic r);
        send_word(key_time + TW'(span), r, 1'b0, '0);
    endtask

    // Span strictly between lo and hi; random when that range is empty.
    function automatic int pick_between(input int lo, input int hi);
        if (hi - lo < 2)
            return $urandom_range(0, 65535);
        return $urandom_range(lo + 1, hi - 1);
    endfunction

    // Span above lo, mostly not far above; random when nothing fits in 16 bits.
    function automatic int pick_above(input int lo);
        int hi;
        if (lo >= 65535)
            return $urandom_range(0, 65535);
        hi = lo + 1 + 3 * (lo + 200);
        if (hi > 65535)
            hi = 65535;
        return $urandom_range(lo + 1, hi);
    endfunction

    // One keyed letter: mostly 1-4 symbols, some overlong, some empty,
    // with an occasional bad press and an occasional gap that does not end it.
    task automatic key_letter();
        int nsym;
        int pick;
        int span;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            nsym = 0;
        else if (pick < 3)
            nsym = $urandom_range(5, 6);
        else
            nsym = $urandom_range(1, 4);
        for (int k = 0; k < nsym; k++)
        begin
            key_after($urandom_range(0, gap_min_q), KEY_DOWN);
            pick = $urandom_range(0, 9);
            if (pick == 0)
                span = $urandom_range(0, 1) ? int'(dash_min_q) : $urandom_range(0, dot_min_q);
            else if (pick < 6)
                span = pick_between(dot_min_q, dash_min_q);
            else
                span = pick_above(dash_min_q);
            key_after(span, KEY_UP);
        end
        pick = $urandom_range(0, 19);
        if (pick == 0)
            span = gap_min_q;
        else if (pick == 1)
            span = $urandom_range(0, gap_min_q);
        else
            span = pick_above(gap_min_q);
        key_after(span, KEY_DOWN);
    endtask

    // Sender stops and waits for every owed letter word, then lets the pipe empty.
    task automatic drain_results();
        in_valid <= 1'b0;
        burst_left = 0;
        while (letters_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all three thresholds back to back; cfg_we stays high across them.
    task automatic set_thresholds(input logic [TW-1:0] d, input logic [TW-1:0] a,
                                  input logic [TW-1:0] g);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DOT_MIN;
        cfg_wdata <= d;
        @(posedge clk);
        cfg_index <= REG_DASH_MIN;
        cfg_wdata <= a;
        @(posedge clk);
        cfg_index <= REG_GAP_MIN;
        cfg_wdata <= g;
        @(posedge clk);
        cfg_we     <= 1'b0;
        dot_min_q  = d;
        dash_min_q = a;
        gap_min_q  = g;
    endtask

    task automatic run_phase(input logic [TW-1:0] d, input logic [TW-1:0] a,
                             input logic [TW-1:0] g, input int n);
        int target;
        drain_results();
        set_thresholds(d, a, g);
        target = words_sent + n;
        while (words_sent < target)
        begin
            if ($urandom_range(0, 9) == 0)
                send_word(TW'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), 1'b0, '0);
            else
                key_letter();
        end
    endtask

    // Receiver: windows of always-ready, coin-flip, sparse and mostly-ready,
    // plus one long hold-off on request.
    initial
    begin : sink
        int mode;
        int left;
        mode      = 0;
        left      = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(16, 128);
                end
                left--;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Letter word check, sampled at the falling edge ahead of the accepting edge.
    initial
    begin : check
        letter_word_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (letters_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: letter word with none owed: expected none, %s %h status %0d",
                             $time, "got letter", letter, status);
                end
                else
                begin
                    want = letters_due.pop_front();
                    if (want.letter !== letter)
                    begin
                        errors++;
                        $display("%0t: letter expected %h got %h", $time, want.letter, letter);
                    end
                    if (want.status !== status)
                    begin
                        errors++;
                        $display("%0t: status expected %0d got %0d", $time, want.status, status);
                    end
                end
            end
        end
    end

    // Cycles in which neither channel moved a word.
    always @(negedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("morse_pulse_timing_decoder: mismatch");
        $finish;
    end

    initial
    begin
        int d_pick;
        int a_pick;
        int g_pick;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        capture_time = '0;
        rising       = KEY_UP;
        cfg_we       = 1'b0;
        cfg_index    = REG_DOT_MIN;
        cfg_wdata    = '0;

        for (int i = 0; i < 32; i++)
            morse_char[i] = '0;
        learn_code(".-", "A");   learn_code("-...", "B"); learn_code("-.-.", "C");
        learn_code("-..", "D");  learn_code(".", "E");    learn_code("..-.", "F");
        learn_code("--.", "G");  learn_code("....", "H"); learn_code("..", "I");
        learn_code(".---", "J"); learn_code("-.-", "K");  learn_code(".-..", "L");
        learn_code("--", "M");   learn_code("-.", "N");   learn_code("---", "O");
        learn_code(".--.", "P"); learn_code("--.-", "Q"); learn_code(".-.", "R");
        learn_code("...", "S");  learn_code("-", "T");    learn_code("..-", "U");
        learn_code("...-", "V"); learn_code(".--", "W");  learn_code("-..-", "X");
        learn_code("-.--", "Y"); learn_code("--..", "Z");

        // Directed words at reset thresholds (50 / 2500 / 20000), last edge at 0.
        //       time      edge      typed letter  status
        add_row(16'd30000, KEY_DOWN, 1'b0, 8'h00, ST_OK);      // long gap, store empty
        add_row(16'd30051, KEY_UP,   1'b0, 8'h00, ST_OK);      // 51: just a dot
        add_row(16'd50051, KEY_DOWN, 1'b0, 8'h00, ST_OK);      // gap exactly gap_min
        add_row(16'd4516,  KEY_DOWN, 1'b1, "E",   ST_OK);      // gap 20001 across wrap
        add_row(16'd7016,  KEY_UP,   1'b0, 8'h00, ST_OK);      // exactly dash_min: dropped
        add_row(16'd7066,  KEY_UP,   1'b0, 8'h00, ST_OK);      // exactly dot_min: dropped
        add_row(16'd9567,  KEY_UP,   1'b0, 8'h00, ST_OK);      // 2501: dash
        add_row(16'd9967,  KEY_UP,   1'b0, 8'h00, ST_OK);      // dot
        add_row(16'hFFFF,  KEY_DOWN, 1'b1, "N",   ST_OK);      // timer at max
        add_row(16'd100,   KEY_UP,   1'b0, 8'h00, ST_OK);      // 101 across wrap: dot
        add_row(16'd3100,  KEY_UP,   1'b0, 8'h00, ST_OK);      // dash
        add_row(16'd3300,  KEY_UP,   1'b0, 8'h00, ST_OK);      // dot
        add_row(16'd3500,  KEY_UP,   1'b0, 8'h00, ST_OK);      // dot, four held
        add_row(16'd3700,  KEY_UP,   1'b0, 8'h00, ST_OK);      // fifth symbol
        add_row(16'd33700, KEY_DOWN, 1'b1, 8'h00, ST_LONG);    // overlong letter
        add_row(16'd36700, KEY_UP,   1'b0, 8'h00, ST_OK);      // four dashes ...
        add_row(16'd39700, KEY_UP,   1'b0, 8'h00, ST_OK);
        add_row(16'd42700, KEY_UP,   1'b0, 8'h00, ST_OK);
        add_row(16'd45700, KEY_UP,   1'b0, 8'h00, ST_OK);
        add_row(16'd165,   KEY_DOWN, 1'b1, 8'h00, ST_UNKNOWN); // ... are no letter

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < stim_table.size(); i++)
            send_word(stim_table[i].t, stim_table[i].r, stim_table[i].typed, stim_table[i].w);

        // Threshold sweeps, extremes first.
        run_phase(DOT_MIN_RST, DASH_MIN_RST, GAP_MIN_RST, 250);
        run_phase(16'd0, 16'd0, 16'd0, 100);                    // every nonzero press a dash
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 60);            // nothing can close
        run_phase(16'd0, 16'hFFFF, 16'd0, 100);                 // dots only
        run_phase(16'd3000, 16'd1000, 16'd5000, 100);           // dot window empty

        // Hold the receiver off for a long stretch and keep keying so the
        // op queue fills and the edge channel stalls; then wait it all out.
        drain_results();
        set_thresholds(16'd20, 16'd400, 16'd1500);
        hold_req = 1'b1;
        while (hold_req)
            key_letter();

        for (int p = 0; p < 4; p++)
        begin
            d_pick = $urandom_range(0, 2000);
            a_pick = d_pick + $urandom_range(2, 6000);
            g_pick = a_pick + $urandom_range(0, 40000);
            run_phase(TW'(d_pick), TW'(a_pick), TW'(g_pick), 320);
        end

        drain_results();
        if (errors == 0 && letters_due.size() == 0)
            $display("morse_pulse_timing_decoder: match");
        else
            $display("morse_pulse_timing_decoder: mismatch");
        $finish;
    end

endmodule
